// ===== rtl/prebuffered_byte_jitter_fifo_core_macros.svh =====
// Assertion macros shared by the jitter FIFO checker.
`ifndef PREBUFFERED_BYTE_JITTER_FIFO_CORE_MACROS_SVH
`define PREBUFFERED_BYTE_JITTER_FIFO_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PBJF_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PBJF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pbjf_pkg.sv =====
// Shared types and constants of the prebuffered byte jitter FIFO.
package pbjf_pkg;

  localparam int REQ_W  = 3;
  localparam int BYTE_W = 8;
  localparam int AMT_W  = 13;
  localparam int FILL_W = 13;
  localparam int LVL_W  = 13;

  localparam logic [LVL_W-1:0] LEVEL_RESET = 13'd1024;

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE   = 3'd0,
    REQ_READ    = 3'd1,
    REQ_PEEK    = 3'd2,
    REQ_DISCARD = 3'd3,
    REQ_START   = 3'd4,
    REQ_STOP    = 3'd5
  } req_code_t;

  typedef enum logic {
    ST_IDLE,
    ST_FETCH
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic load_data;
  } ctrl_cmd_t;

  typedef struct packed {
    logic needs_mem;
  } dp_status_t;

endpackage

// ===== rtl/pbjf_req_if.sv =====
// Request channel: valid/ready with one request beat.
interface pbjf_req_if;
  logic                       valid;
  logic                       ready;
  logic [pbjf_pkg::REQ_W-1:0]  req_type;
  logic [pbjf_pkg::BYTE_W-1:0] data_byte;
  logic [pbjf_pkg::AMT_W-1:0]  amount;

  modport source (output valid, output req_type, output data_byte, output amount,
                  input ready);
  modport sink (input valid, input req_type, input data_byte, input amount,
                output ready);
endinterface

// ===== rtl/pbjf_rsp_if.sv =====
// Result channel: valid/ready with one result beat.
interface pbjf_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [pbjf_pkg::BYTE_W-1:0] read_data;
  logic                        from_buffer;
  logic                        gated;
  logic                        write_dropped;
  logic [pbjf_pkg::FILL_W-1:0] fill_level;
  logic                        playing;

  modport source (output valid, output read_data, output from_buffer, output gated,
                  output write_dropped, output fill_level, output playing,
                  input ready);
  modport sink (input valid, input read_data, input from_buffer, input gated,
                input write_dropped, input fill_level, input playing,
                output ready);
endinterface

// ===== rtl/pbjf_cfg_if.sv =====
// Configuration write channel carrying the prebuffer level.
interface pbjf_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [pbjf_pkg::LVL_W-1:0] prebuffer_level;

  modport source (output valid, output prebuffer_level, input ready);
  modport sink (input valid, input prebuffer_level, output ready);
endinterface

// ===== rtl/pbjf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pbjf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/pbjf_ctrl.sv =====
// Controller: request acceptance, ring fetch sequencing and result valid.
module pbjf_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  output logic                   rsp_valid,
  input  logic                   rsp_ready,
  input  pbjf_pkg::dp_status_t   status,
  output pbjf_pkg::ctrl_cmd_t    cmd
);

  pbjf_pkg::ctrl_state_t state, state_next;
  logic                  rsp_valid_next;
  logic                  out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pbjf_pkg::ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    out_free       = !rsp_valid || rsp_ready;
    state_next     = state;
    rsp_valid_next = rsp_valid && !rsp_ready;
    req_ready      = 1'b0;
    cmd.accept     = 1'b0;
    cmd.load_data  = 1'b0;
    case (state)
      pbjf_pkg::ST_IDLE: begin
        req_ready  = out_free;
        cmd.accept = req_valid && out_free;
        if (cmd.accept) begin
          // hold the result back until the ring read returns
          if (status.needs_mem) begin
            state_next     = pbjf_pkg::ST_FETCH;
            rsp_valid_next = 1'b0;
          end else begin
            rsp_valid_next = 1'b1;
          end
        end
      end
      pbjf_pkg::ST_FETCH: begin
        cmd.load_data  = 1'b1;
        rsp_valid_next = 1'b1;
        state_next     = pbjf_pkg::ST_IDLE;
      end
      default: begin
        state_next = pbjf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/pbjf_datapath.sv =====
// Datapath: pointers, fill count, stream flags, ring RAM and result register.
module pbjf_datapath #(
  parameter int RING_DEPTH = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  pbjf_pkg::ctrl_cmd_t         cmd,
  output pbjf_pkg::dp_status_t        status,
  input  logic [pbjf_pkg::REQ_W-1:0]  req_type,
  input  logic [pbjf_pkg::BYTE_W-1:0] data_byte,
  input  logic [pbjf_pkg::AMT_W-1:0]  amount,
  input  logic                        cfg_write,
  input  logic [pbjf_pkg::LVL_W-1:0]  prebuffer_level,
  output logic [pbjf_pkg::BYTE_W-1:0] read_data,
  output logic                        from_buffer,
  output logic                        gated,
  output logic                        write_dropped,
  output logic [pbjf_pkg::FILL_W-1:0] fill_level,
  output logic                        playing
);

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int CMP_W = (CNT_W > pbjf_pkg::AMT_W) ? CNT_W : pbjf_pkg::AMT_W;

  logic [PTR_W-1:0]           wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0]           rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0]           fill, fill_next;
  logic                       active, active_next;
  logic                       done, done_next;
  logic [pbjf_pkg::LVL_W-1:0] level;

  logic                       gate;
  logic                       full;
  logic [PTR_W-1:0]           wr_inc, rd_inc;
  logic [SUM_W-1:0]           peek_sum, disc_sum;
  logic [PTR_W-1:0]           peek_addr, disc_ptr;
  logic [CNT_W-1:0]           disc_n;

  logic                       mem_we, mem_re;
  logic [PTR_W-1:0]           mem_raddr;
  logic [pbjf_pkg::BYTE_W-1:0] mem_rdata;
  logic                       gated_next, dropped_next;

  assign gate = !active || (!done && (CMP_W'(fill) < CMP_W'(level)));
  assign full = (fill >= CNT_W'(RING_DEPTH));

  assign wr_inc = (wr_ptr == PTR_W'(RING_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
  assign rd_inc = (rd_ptr == PTR_W'(RING_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;

  // offsets stay below the fill when used, so one wrap subtract suffices
  assign peek_sum  = SUM_W'(rd_ptr) + SUM_W'(CNT_W'(amount));
  assign peek_addr = (peek_sum >= SUM_W'(RING_DEPTH)) ?
                     PTR_W'(peek_sum - SUM_W'(RING_DEPTH)) : PTR_W'(peek_sum);

  assign disc_n   = (CMP_W'(amount) > CMP_W'(fill)) ? fill : CNT_W'(amount);
  assign disc_sum = SUM_W'(rd_ptr) + SUM_W'(disc_n);
  assign disc_ptr = (disc_sum >= SUM_W'(RING_DEPTH)) ?
                    PTR_W'(disc_sum - SUM_W'(RING_DEPTH)) : PTR_W'(disc_sum);

  always_comb begin
    wr_ptr_next      = wr_ptr;
    rd_ptr_next      = rd_ptr;
    fill_next        = fill;
    active_next      = active;
    done_next        = done;
    mem_raddr        = rd_ptr;
    mem_we           = 1'b0;
    gated_next       = 1'b0;
    dropped_next     = 1'b0;
    status.needs_mem = 1'b0;
    case (pbjf_pkg::req_code_t'(req_type))
      pbjf_pkg::REQ_WRITE: begin
        if (!active || full) begin
          dropped_next = 1'b1;
        end else begin
          mem_we      = 1'b1;
          wr_ptr_next = wr_inc;
          fill_next   = fill + 1'b1;
        end
      end
      pbjf_pkg::REQ_READ: begin
        if (gate) begin
          gated_next = 1'b1;
        end else begin
          done_next = 1'b1;
          if (fill != '0) begin
            status.needs_mem = 1'b1;
            rd_ptr_next      = rd_inc;
            fill_next        = fill - 1'b1;
          end
        end
      end
      pbjf_pkg::REQ_PEEK: begin
        if (gate) begin
          gated_next = 1'b1;
        end else begin
          done_next = 1'b1;
          mem_raddr = peek_addr;
          if (CMP_W'(amount) < CMP_W'(fill)) begin
            status.needs_mem = 1'b1;
          end
        end
      end
      pbjf_pkg::REQ_DISCARD: begin
        if (active) begin
          rd_ptr_next = disc_ptr;
          fill_next   = fill - disc_n;
        end
      end
      pbjf_pkg::REQ_START: begin
        active_next = 1'b1;
        done_next   = 1'b0;
      end
      pbjf_pkg::REQ_STOP: begin
        active_next = 1'b0;
        done_next   = 1'b0;
        wr_ptr_next = '0;
        rd_ptr_next = '0;
        fill_next   = '0;
      end
      default: begin
      end
    endcase
  end

  assign mem_re = cmd.accept && status.needs_mem;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
      active <= 1'b0;
      done   <= 1'b0;
      level  <= pbjf_pkg::LEVEL_RESET;
    end else begin
      if (cfg_write) begin
        level <= prebuffer_level;
      end
      if (cmd.accept) begin
        wr_ptr <= wr_ptr_next;
        rd_ptr <= rd_ptr_next;
        fill   <= fill_next;
        active <= active_next;
        done   <= done_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      read_data     <= '0;
      from_buffer   <= status.needs_mem;
      gated         <= gated_next;
      write_dropped <= dropped_next;
      fill_level    <= pbjf_pkg::FILL_W'(fill_next);
      playing       <= done_next;
    end else if (cmd.load_data) begin
      read_data <= mem_rdata;
    end
  end

  pbjf_ram #(
    .WIDTH (pbjf_pkg::BYTE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (cmd.accept && mem_we),
    .wr_addr (wr_ptr),
    .wr_data (data_byte),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

endmodule

// ===== rtl/prebuffered_byte_jitter_fifo_core.sv =====
// Top level of the prebuffered byte jitter FIFO: controller plus datapath.
//
//   channel  dir  payload                                      handshake
//   req      in   req_type, data_byte, amount                  valid/ready
//   rsp      out  read_data, from_buffer, gated, write_dropped,
//                 fill_level, playing                          valid/ready
//   cfg      in   prebuffer_level                              valid/ready
//
// One request beat gives exactly one result beat. A read or peek that fetches a
// stored byte passes through the fetch state, as the ring RAM has a registered
// read port; every other request (gated, empty or out-of-range reads and peeks
// too) skips it. A new request is taken while the previous result is being taken;
// the input stalls in the fetch state and while a result waits with rsp.ready low.
// rst is synchronous; it clears pointers, fill, flags and sets the prebuffer
// level to 1024. The ring needs no clearing pass: unwritten entries are never read.
// cfg is always ready; write it only while no request is in flight.
module prebuffered_byte_jitter_fifo_core #(
  parameter int RING_DEPTH = 4096
) (
  input logic         clk,
  input logic         rst,
  pbjf_req_if.sink    req,
  pbjf_rsp_if.source  rsp,
  pbjf_cfg_if.sink    cfg
);

  pbjf_pkg::ctrl_cmd_t  cmd;
  pbjf_pkg::dp_status_t status;

  // level register accepts every write beat
  assign cfg.ready = 1'b1;

  // sequence accept, fetch and result valid
  pbjf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // pointers, fill, flags, ring and result register
  pbjf_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .req_type        (req.req_type),
    .data_byte       (req.data_byte),
    .amount          (req.amount),
    .cfg_write       (cfg.valid),
    .prebuffer_level (cfg.prebuffer_level),
    .read_data       (rsp.read_data),
    .from_buffer     (rsp.from_buffer),
    .gated           (rsp.gated),
    .write_dropped   (rsp.write_dropped),
    .fill_level      (rsp.fill_level),
    .playing         (rsp.playing)
  );

endmodule

// ===== rtl/pbjf_checker.sv =====
// Port-level checker for the jitter FIFO result channel, bound to the top level.
`include "prebuffered_byte_jitter_fifo_core_macros.svh"

module pbjf_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [pbjf_pkg::BYTE_W-1:0] read_data,
  input logic                        from_buffer,
  input logic                        gated,
  input logic                        write_dropped,
  input logic [pbjf_pkg::FILL_W-1:0] fill_level,
  input logic                        playing
);

  `PBJF_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")
  `PBJF_ASSERT_NEXT(a_rsp_stable, clk, rst, rsp_valid && !rsp_ready, $stable(read_data) && $stable(fill_level) && $stable(playing), "result changed while stalled")
  `PBJF_ASSERT_IMPLY(a_gated_silent, clk, rst, rsp_valid && gated, !playing && !from_buffer, "gated result while playing or from ring")
  `PBJF_ASSERT_IMPLY(a_zero_fill, clk, rst, rsp_valid && !from_buffer, read_data == '0, "nonzero byte not from ring")
  `PBJF_ASSERT_IMPLY(a_drop_excl, clk, rst, rsp_valid && write_dropped, !gated && !from_buffer, "dropped write flagged as read")

endmodule

bind prebuffered_byte_jitter_fifo_core pbjf_checker u_pbjf_checker (
  .clk           (clk),
  .rst           (rst),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .read_data     (rsp.read_data),
  .from_buffer   (rsp.from_buffer),
  .gated         (rsp.gated),
  .write_dropped (rsp.write_dropped),
  .fill_level    (rsp.fill_level),
  .playing       (rsp.playing)
);

// ===== sim/prebuffered_byte_jitter_fifo_core_test.sv =====
// Self-checking testbench of the prebuffered byte jitter FIFO core.
module prebuffered_byte_jitter_fifo_core_test;

  localparam int RING_DEPTH   = 4096;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 6;
  localparam int PHASE_ITEMS  = 80;

  // Request codes the block must treat as no-ops.
  localparam logic [pbjf_pkg::REQ_W-1:0] REQ_SPARE_A = 3'd6;
  localparam logic [pbjf_pkg::REQ_W-1:0] REQ_SPARE_B = 3'd7;

  // A level above the ring depth: the stream is never released.
  localparam logic [pbjf_pkg::LVL_W-1:0] LEVEL_NEVER = 13'h1FFF;

  typedef struct packed {
    logic [pbjf_pkg::BYTE_W-1:0] read_data;
    logic                        from_buffer;
    logic                        gated;
    logic                        write_dropped;
    logic [pbjf_pkg::FILL_W-1:0] fill_level;
    logic                        playing;
  } result_t;

  // Shadow copy of the FIFO: predicts one result per request beat and holds
  // the predictions until the matching result beat shows up.
  class jitter_fifo_shadow;
    logic [pbjf_pkg::BYTE_W-1:0] ring [RING_DEPTH];
    int                wr_ptr;
    int                rd_ptr;
    int                fill;
    int                level;
    bit                active;
    bit                released;
    result_t           pending_results[$];
    int                mismatches;
    int                results_seen;
    int                buffered_bytes;
    int                gated_reads;
    int                dropped_writes;

    function new();
      level = int'(pbjf_pkg::LEVEL_RESET);
    endfunction

    function void set_level(logic [pbjf_pkg::LVL_W-1:0] lvl);
      level = int'(lvl);
    endfunction

    // Close the gate while inactive or still prebuffering; latch the release.
    function bit gate_shut();
      if (!active) return 1'b1;
      if (!released) begin
        if (fill < level) return 1'b1;
        released = 1'b1;
      end
      return 1'b0;
    endfunction

    function void take_request(logic [pbjf_pkg::REQ_W-1:0] code,
                               logic [pbjf_pkg::BYTE_W-1:0] data,
                               logic [pbjf_pkg::AMT_W-1:0] amount);
      result_t want;
      int      n;
      want = '0;
      case (code)
        pbjf_pkg::REQ_WRITE: begin
          if (!active || fill >= RING_DEPTH) begin
            want.write_dropped = 1'b1;
          end else begin
            ring[wr_ptr] = data;
            wr_ptr = (wr_ptr + 1) % RING_DEPTH;
            fill++;
          end
        end
        pbjf_pkg::REQ_READ: begin
          if (gate_shut()) begin
            want.gated = 1'b1;
          end else if (fill > 0) begin
            want.read_data = ring[rd_ptr];
            want.from_buffer = 1'b1;
            rd_ptr = (rd_ptr + 1) % RING_DEPTH;
            fill--;
          end
        end
        pbjf_pkg::REQ_PEEK: begin
          if (gate_shut()) begin
            want.gated = 1'b1;
          end else if (int'(amount) < fill) begin
            want.read_data = ring[(rd_ptr + int'(amount)) % RING_DEPTH];
            want.from_buffer = 1'b1;
          end
        end
        pbjf_pkg::REQ_DISCARD: begin
          if (active) begin
            n = (int'(amount) > fill) ? fill : int'(amount);
            rd_ptr = (rd_ptr + n) % RING_DEPTH;
            fill -= n;
          end
        end
        pbjf_pkg::REQ_START: begin
          active = 1'b1;
          released = 1'b0;
        end
        pbjf_pkg::REQ_STOP: begin
          active = 1'b0;
          released = 1'b0;
          wr_ptr = 0;
          rd_ptr = 0;
          fill = 0;
        end
        default: ;
      endcase
      want.fill_level = pbjf_pkg::FILL_W'(fill);
      want.playing = released;
      pending_results.push_back(want);
    endfunction

    function void report(string what, result_t want, result_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%s: want data=%02h buf=%0b gated=%0b drop=%0b fill=%0d play=%0b",
                 what, want.read_data, want.from_buffer, want.gated,
                 want.write_dropped, want.fill_level, want.playing,
                 "\n  got data=%02h buf=%0b gated=%0b drop=%0b fill=%0d play=%0b",
                 got.read_data, got.from_buffer, got.gated,
                 got.write_dropped, got.fill_level, got.playing);
    endfunction

    function void match_result(logic [pbjf_pkg::BYTE_W-1:0] read_data,
                               logic from_buffer, logic gated, logic write_dropped,
                               logic [pbjf_pkg::FILL_W-1:0] fill_level,
                               logic playing);
      result_t got;
      result_t want;
      got = '{read_data, from_buffer, gated, write_dropped, fill_level, playing};
      results_seen++;
      if (pending_results.size() == 0) begin
        report("unexpected result beat", '0, got);
        return;
      end
      want = pending_results.pop_front();
      if (want.from_buffer) buffered_bytes++;
      if (want.gated) gated_reads++;
      if (want.write_dropped) dropped_writes++;
      if (got.read_data !== want.read_data || got.from_buffer !== want.from_buffer ||
          got.gated !== want.gated || got.write_dropped !== want.write_dropped ||
          got.fill_level !== want.fill_level || got.playing !== want.playing)
        report("result mismatch", want, got);
    endfunction
  endclass

  logic clk;
  logic rst;

  pbjf_req_if req();
  pbjf_rsp_if rsp();
  pbjf_cfg_if cfg();

  jitter_fifo_shadow shadow = new();

  bit idle_on   = 1'b1;  // random gaps on both sides
  bit hold_ask  = 1'b0;  // ask the result side for one long hold-off
  bit drv_active = 1'b0; // driver's own view of the stream flag
  int items_sent = 0;    // beats that do more than get ignored
  int levels_used = 0;

  prebuffered_byte_jitter_fifo_core #(
    .RING_DEPTH(RING_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .cfg(cfg)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

  // Monitor both channels on the clock edge. Note the request beat first so a
  // prediction is always in place before its result can be checked.
  always @(posedge clk) begin
    if (!rst && req.valid && req.ready)
      shadow.take_request(req.req_type, req.data_byte, req.amount);
    if (!rst && rsp.valid && rsp.ready)
      shadow.match_result(rsp.read_data, rsp.from_buffer, rsp.gated,
                          rsp.write_dropped, rsp.fill_level, rsp.playing);
  end

  // Result side: random stall bursts, plus one long hold-off on request. The
  // hold is counted here so the sender keeps offering beats meanwhile.
  initial begin : result_sink
    int hold_left;
    int stall_left;
    hold_left = 0;
    stall_left = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ask) begin
        hold_ask = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 12);
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // Offer one request beat and hold it until it is taken. Call at a clock
  // edge; returns at the edge that accepted the beat, with valid still high
  // so back-to-back beats need no second assignment in one step.
  task automatic send(input logic [pbjf_pkg::REQ_W-1:0] code,
                      input logic [pbjf_pkg::BYTE_W-1:0] data = '0,
                      input logic [pbjf_pkg::AMT_W-1:0] amount = '0);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.req_type  <= code;
    req.data_byte <= data;
    req.amount    <= amount;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    // Count only beats that are not simply ignored: spare codes, and writes or discards to an idle stream.
    if (code <= pbjf_pkg::REQ_STOP &&
        (drv_active || (code != pbjf_pkg::REQ_WRITE && code != pbjf_pkg::REQ_DISCARD)))
      items_sent++;
    if (code == pbjf_pkg::REQ_START) drv_active = 1'b1;
    if (code == pbjf_pkg::REQ_STOP) drv_active = 1'b0;
  endtask

  // Drop valid and wait for every predicted result, then let the block's
  // fetch path run dry before anything else happens.
  task automatic settle();
    req.valid <= 1'b0;
    do @(posedge clk); while (shadow.pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the prebuffer level only with the block idle.
  task automatic write_level(input logic [pbjf_pkg::LVL_W-1:0] lvl);
    settle();
    cfg.valid           <= 1'b1;
    cfg.prebuffer_level <= lvl;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    shadow.set_level(lvl);
    levels_used++;
  endtask

  // Random traffic under one prebuffer level. Mostly a started stream with
  // writes ahead of reads so the gate opens; the rest is noise: stops,
  // restarts, spare codes, oversized peeks and discards.
  task automatic play_phase(input logic [pbjf_pkg::LVL_W-1:0] lvl, input int budget,
                            input bit squeeze);
    int                          start_count;
    int                          pick;
    logic [pbjf_pkg::REQ_W-1:0]  code;
    logic [pbjf_pkg::BYTE_W-1:0] data;
    logic [pbjf_pkg::AMT_W-1:0]  amount;
    write_level(lvl);
    if (squeeze) hold_ask = 1'b1;
    start_count = items_sent;
    while (items_sent - start_count < budget) begin
      pick = $urandom_range(0, 99);
      data = pbjf_pkg::BYTE_W'($urandom_range(0, 255));
      if ($urandom_range(0, 4) == 0)
        amount = pbjf_pkg::AMT_W'($urandom_range(0, 4096));
      else
        amount = pbjf_pkg::AMT_W'($urandom_range(0, 6));
      if (!drv_active && pick < 85) code = pbjf_pkg::REQ_START;
      else if (pick < 45) code = pbjf_pkg::REQ_WRITE;
      else if (pick < 68) code = pbjf_pkg::REQ_READ;
      else if (pick < 80) code = pbjf_pkg::REQ_PEEK;
      else if (pick < 87) code = pbjf_pkg::REQ_DISCARD;
      else if (pick < 89) code = pbjf_pkg::REQ_START;
      else if (pick < 92) code = pbjf_pkg::REQ_STOP;
      else if (pick < 94) code = REQ_SPARE_A;
      else if (pick < 96) code = REQ_SPARE_B;
      else code = pbjf_pkg::REQ_READ;
      send(code, data, amount);
    end
  endtask

  initial begin : stimulus
    rst                 <= 1'b1;
    req.valid           <= 1'b0;
    req.req_type        <= pbjf_pkg::REQ_WRITE;
    req.data_byte       <= '0;
    req.amount          <= '0;
    cfg.valid           <= 1'b0;
    cfg.prebuffer_level <= pbjf_pkg::LEVEL_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset level: everything gated or dropped while the stream is idle.
    send(pbjf_pkg::REQ_READ);
    send(pbjf_pkg::REQ_PEEK, '0, '0);
    send(pbjf_pkg::REQ_WRITE, 8'hFF);
    send(pbjf_pkg::REQ_DISCARD, '0, 13'd4096);
    send(REQ_SPARE_A, 8'hFF, 13'h1FFF);
    send(REQ_SPARE_B);
    send(pbjf_pkg::REQ_START);
    send(pbjf_pkg::REQ_WRITE, 8'h00);
    send(pbjf_pkg::REQ_WRITE, 8'hFF);
    send(pbjf_pkg::REQ_READ);                    // still prebuffering
    send(pbjf_pkg::REQ_PEEK, '0, 13'h1FFF);
    send(pbjf_pkg::REQ_DISCARD, '0, 13'd1);
    send(pbjf_pkg::REQ_START);                   // restart while already running
    send(pbjf_pkg::REQ_STOP);

    // Level zero: released on the first read, even at empty fill.
    write_level('0);
    send(pbjf_pkg::REQ_START);
    send(pbjf_pkg::REQ_READ);                    // underrun
    send(pbjf_pkg::REQ_WRITE, 8'hA5);
    send(pbjf_pkg::REQ_WRITE, 8'h5A);
    send(pbjf_pkg::REQ_PEEK, '0, 13'd1);
    send(pbjf_pkg::REQ_PEEK, '0, 13'd2);         // offset at fill
    send(pbjf_pkg::REQ_PEEK, '0, 13'h1FFF);
    send(pbjf_pkg::REQ_READ);
    send(pbjf_pkg::REQ_DISCARD, '0, 13'd4096);   // larger than fill
    send(pbjf_pkg::REQ_READ);
    send(pbjf_pkg::REQ_STOP);

    // Random traffic; the second phase also holds the result side off long
    // enough to back the block up into its request port.
    play_phase(13'd0, PHASE_ITEMS, 1'b0);
    play_phase(13'd1, PHASE_ITEMS, 1'b1);
    play_phase(13'd4, PHASE_ITEMS, 1'b0);
    play_phase(13'd12, PHASE_ITEMS, 1'b0);
    play_phase(13'd32, PHASE_ITEMS, 1'b0);

    // Level beyond the ring: the gate never opens.
    write_level(LEVEL_NEVER);
    send(pbjf_pkg::REQ_START);
    repeat (10) send(pbjf_pkg::REQ_WRITE, pbjf_pkg::BYTE_W'($urandom_range(0, 255)));
    send(pbjf_pkg::REQ_READ);
    send(pbjf_pkg::REQ_PEEK, '0, '0);
    send(pbjf_pkg::REQ_STOP);

    // Last stretch at full rate on both sides.
    idle_on = 1'b0;
    play_phase(13'd2, 60, 1'b0);

    settle();
    $display("Covered %0d request beats over %0d prebuffer levels.",
             items_sent, levels_used);
    $display("Checked %0d results: %0d buffered bytes, %0d gated, %0d dropped writes.",
             shadow.results_seen, shadow.buffered_bytes, shadow.gated_reads,
             shadow.dropped_writes);
    if (shadow.mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/pbjf_pkg.sv
rtl/pbjf_req_if.sv
rtl/pbjf_rsp_if.sv
rtl/pbjf_cfg_if.sv
rtl/pbjf_ram.sv
rtl/pbjf_ctrl.sv
rtl/pbjf_datapath.sv
rtl/prebuffered_byte_jitter_fifo_core.sv
rtl/pbjf_checker.sv
sim/prebuffered_byte_jitter_fifo_core_test.sv
